### sv/ssfs_pkg.sv
// shared types, constants and an arithmetic helper for the switch/sensor frame scheduler
// no dependencies
package ssfs_pkg;

    localparam int ID_W      = 11;
    localparam int LEN_W     = 2;
    localparam int PAYLOAD_W = 24;
    localparam int CMD_W     = 2;
    localparam int ADC_W     = 10;
    localparam int STATUS_W  = 3;
    localparam int SUM_W     = 14;
    localparam int PERIOD_W  = 8;
    localparam int SPEED_W   = 7;
    localparam int TEMP_W    = 8;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int AVG_WINDOW_DEF = 10;

    localparam logic [SUM_W-1:0]     SUM_MAX       = 14'd16383;
    localparam logic [ADC_W-1:0]     ADC_MAX       = 10'd1023;
    localparam logic [6:0]           SPEED_SCALE   = 7'd120;
    localparam logic [8:0]           TEMP_SCALE    = 9'd330;
    localparam logic [8:0]           TEMP_OFFSET   = 9'd50;
    localparam logic [8:0]           TEMP_CLAMP    = 9'd255;
    localparam logic [LEN_W-1:0]     LEN_EVENT     = 2'd1;
    localparam logic [LEN_W-1:0]     LEN_PERIODIC  = 2'd3;

    localparam logic [ID_W-1:0]      EVT_ID_RST      = 11'd16;
    localparam logic [ID_W-1:0]      PERIODIC_ID_RST = 11'd80;
    localparam logic [PERIOD_W-1:0]  SEND_PERIOD_RST = 8'd15;
    localparam logic [PERIOD_W-1:0]  TEMP_PERIOD_RST = 8'd20;

    typedef enum logic [CMD_W-1:0] {
        CMD_HEADLIGHT = 2'd0,
        CMD_LEFT      = 2'd1,
        CMD_RIGHT     = 2'd2,
        CMD_TICK      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_EVT_ID      = 2'd0,
        REG_PERIODIC_ID = 2'd1,
        REG_SEND_PERIOD = 2'd2,
        REG_TEMP_PERIOD = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0]     evt_id;
        logic [ID_W-1:0]     periodic_id;
        logic [PERIOD_W-1:0] send_period;
        logic [PERIOD_W-1:0] temp_period;
    } cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]      frame_id;
        logic [LEN_W-1:0]     frame_length;
        logic [PAYLOAD_W-1:0] payload;
    } frame_t;

    // floor(x / 1023) for x below 2^19, one correction step is enough
    function automatic logic [8:0] div_1023(input logic [18:0] x);
        logic [8:0]  q0;
        logic [10:0] r;
        q0 = x[18:10];
        r  = {1'b0, x[9:0]} + {2'b0, q0};
        return q0 + {8'd0, (r >= {1'b0, ADC_MAX})};
    endfunction

endpackage

### sv/switch_sensor_frame_scheduler_core.sv
// top level: request input register, processing engine, frame output register, apb registers
// depends on ssfs_pkg, ssfs_apb_regs, ssfs_engine
//
//   channel | ports                                    | role
//   s_      | s_valid s_ready s_cmd s_speed_sample ... | press and tick requests in
//   m_      | m_valid m_ready m_frame_id ...           | event and periodic frames out
//   apb     | psel penable pwrite paddr pwdata prdata  | frame ids and periods
//
// a request is registered, then processed combinationally into the frame register
// one request per cycle unless m_ready low stalls the frame register
// m_ready low holds the frame register, and the input register fills behind it
// aresetn is synchronous, active low, and clears all control and state registers
module switch_sensor_frame_scheduler_core import ssfs_pkg::*; #(
    parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [ADC_W-1:0]      s_speed_sample,
    input  logic [ADC_W-1:0]      s_temp_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ID_W-1:0]       m_frame_id,
    output logic [LEN_W-1:0]      m_frame_length,
    output logic [PAYLOAD_W-1:0]  m_payload,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic             in_valid_reg;
    cmd_t             in_cmd_reg;
    logic [ADC_W-1:0] in_speed_reg;
    logic [ADC_W-1:0] in_temp_reg;
    logic             m_valid_reg;
    frame_t           m_frame_reg;
    logic             out_free;
    logic             step;
    logic             res_valid;
    frame_t           res;
    cfg_t             cfg;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign m_valid        = m_valid_reg;
    assign m_frame_id     = m_frame_reg.frame_id;
    assign m_frame_length = m_frame_reg.frame_length;
    assign m_payload      = m_frame_reg.payload;

    ssfs_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ssfs_engine #(
        .AVG_WINDOW (AVG_WINDOW)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .cmd          (in_cmd_reg),
        .speed_sample (in_speed_reg),
        .temp_sample  (in_temp_reg),
        .cfg          (cfg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg   <= cmd_t'(s_cmd);
            in_speed_reg <= s_speed_sample;
            in_temp_reg  <= s_temp_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            m_frame_reg <= res;
        end
    end

endmodule

### sv/ssfs_apb_regs.sv
// apb configuration registers: frame ids and tick periods
// depends on ssfs_pkg
module ssfs_apb_regs import ssfs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_EVT_ID:      cfg_next.evt_id      = pwdata[ID_W-1:0];
                REG_PERIODIC_ID: cfg_next.periodic_id = pwdata[ID_W-1:0];
                REG_SEND_PERIOD: cfg_next.send_period = pwdata[PERIOD_W-1:0];
                REG_TEMP_PERIOD: cfg_next.temp_period = pwdata[PERIOD_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_EVT_ID:      prdata = {{(APB_DATA_W-ID_W){1'b0}}, cfg_reg.evt_id};
            REG_PERIODIC_ID: prdata = {{(APB_DATA_W-ID_W){1'b0}}, cfg_reg.periodic_id};
            REG_SEND_PERIOD: prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, cfg_reg.send_period};
            REG_TEMP_PERIOD: prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, cfg_reg.temp_period};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.evt_id      <= EVT_ID_RST;
            cfg_reg.periodic_id <= PERIODIC_ID_RST;
            cfg_reg.send_period <= SEND_PERIOD_RST;
            cfg_reg.temp_period <= TEMP_PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/ssfs_engine.sv
// switch status, speed averaging, temperature conversion and frame selection
// depends on ssfs_pkg
module ssfs_engine import ssfs_pkg::*; #(
    parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  cmd_t             cmd,
    input  logic [ADC_W-1:0] speed_sample,
    input  logic [ADC_W-1:0] temp_sample,
    input  cfg_t             cfg,
    output logic             res_valid,
    output frame_t           res
);

    localparam int CNT_W     = $clog2(AVG_WINDOW + 1);
    localparam int AVG_SHIFT = SUM_W + $clog2(AVG_WINDOW);
    localparam int AVG_MULT  = ((1 << AVG_SHIFT) + AVG_WINDOW - 1) / AVG_WINDOW;
    localparam int PROD_W    = SUM_W + 16;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [STATUS_W-1:0] last_sent_reg, last_sent_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    avg_cnt_reg, avg_cnt_next;
    logic [PERIOD_W-1:0] send_cnt_reg, send_cnt_next;
    logic [PERIOD_W-1:0] temp_cnt_reg, temp_cnt_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [TEMP_W-1:0]   temp_reg, temp_next;

    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_sat;
    logic [CNT_W-1:0]    avg_cnt_inc;
    logic [PERIOD_W-1:0] send_cnt_inc;
    logic [PERIOD_W-1:0] temp_cnt_inc;
    logic [PROD_W-1:0]   avg_prod;
    logic [SUM_W-1:0]    avg_raw;
    logic [ADC_W-1:0]    avg;
    logic [8:0]          speed_q;
    logic [8:0]          deg;
    logic [STATUS_W-1:0] press_status;
    logic                window_done;
    logic                send_due;
    logic                temp_due;

    // tick datapath
    assign sum_add      = {1'b0, sum_reg} + {{(SUM_W+1-ADC_W){1'b0}}, speed_sample};
    assign sum_sat      = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    assign avg_cnt_inc  = avg_cnt_reg + CNT_W'(1);
    assign send_cnt_inc = send_cnt_reg + PERIOD_W'(1);
    assign temp_cnt_inc = temp_cnt_reg + PERIOD_W'(1);
    assign window_done  = (avg_cnt_inc >= CNT_W'(AVG_WINDOW));
    assign send_due     = (send_cnt_inc >= cfg.send_period);
    assign temp_due     = (temp_cnt_inc >= cfg.temp_period);

    assign avg_prod = PROD_W'(sum_sat) * PROD_W'(AVG_MULT);
    assign avg_raw  = SUM_W'(avg_prod >> AVG_SHIFT);
    assign avg      = (avg_raw > {{(SUM_W-ADC_W){1'b0}}, ADC_MAX}) ? ADC_MAX : avg_raw[ADC_W-1:0];
    assign speed_q  = div_1023(19'(avg) * 19'(SPEED_SCALE));
    assign deg      = div_1023(19'(temp_sample) * 19'(TEMP_SCALE));

    always_comb begin
        press_status = status_reg;
        case (cmd)
            CMD_HEADLIGHT: press_status = status_reg ^ 3'b001;
            CMD_LEFT:      press_status = (status_reg ^ 3'b010) & 3'b011;
            CMD_RIGHT:     press_status = (status_reg ^ 3'b100) & 3'b101;
            default:       press_status = status_reg;
        endcase
    end

    always_comb begin
        status_next    = status_reg;
        last_sent_next = last_sent_reg;
        sum_next       = sum_reg;
        avg_cnt_next   = avg_cnt_reg;
        send_cnt_next  = send_cnt_reg;
        temp_cnt_next  = temp_cnt_reg;
        speed_next     = speed_reg;
        temp_next      = temp_reg;
        res_valid      = 1'b0;
        res            = '0;
        if (cmd != CMD_TICK) begin
            status_next = press_status;
            if (press_status != last_sent_reg) begin
                last_sent_next   = press_status;
                res_valid        = 1'b1;
                res.frame_id     = cfg.evt_id;
                res.frame_length = LEN_EVENT;
                res.payload      = {{(PAYLOAD_W-STATUS_W){1'b0}}, press_status};
            end
        end else begin
            sum_next      = sum_sat;
            avg_cnt_next  = avg_cnt_inc;
            send_cnt_next = send_cnt_inc;
            temp_cnt_next = temp_cnt_inc;
            if (window_done) begin
                speed_next   = speed_q[SPEED_W-1:0];
                sum_next     = '0;
                avg_cnt_next = '0;
            end
            if (send_due) begin
                send_cnt_next    = '0;
                res_valid        = 1'b1;
                res.frame_id     = cfg.periodic_id;
                res.frame_length = LEN_PERIODIC;
                res.payload      = {5'd0, status_reg, temp_reg, 1'b0, speed_next};
            end
            if (temp_due) begin
                temp_cnt_next = '0;
                if (deg < TEMP_OFFSET) begin
                    temp_next = '0;
                end else if ((deg - TEMP_OFFSET) > TEMP_CLAMP) begin
                    temp_next = TEMP_CLAMP[TEMP_W-1:0];
                end else begin
                    temp_next = TEMP_W'(deg - TEMP_OFFSET);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= '0;
            last_sent_reg <= '0;
            sum_reg       <= '0;
            avg_cnt_reg   <= '0;
            send_cnt_reg  <= '0;
            temp_cnt_reg  <= '0;
            speed_reg     <= '0;
            temp_reg      <= '0;
        end else if (step) begin
            status_reg    <= status_next;
            last_sent_reg <= last_sent_next;
            sum_reg       <= sum_next;
            avg_cnt_reg   <= avg_cnt_next;
            send_cnt_reg  <= send_cnt_next;
            temp_cnt_reg  <= temp_cnt_next;
            speed_reg     <= speed_next;
            temp_reg      <= temp_next;
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// testbench for switch_sensor_frame_scheduler_core: directed and random press/tick requests,
// an in-bench model of the scheduler predicts each frame and the monitor checks them in order
// depends on ssfs_pkg and the core rtl
module tb;
    import ssfs_pkg::*;

    localparam int AVG_WIN     = AVG_WINDOW_DEF;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        cmd_t             cmd;
        logic [ADC_W-1:0] speed;
        logic [ADC_W-1:0] temp;
    } request_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd = '0;
    logic [ADC_W-1:0]      s_speed_sample = '0;
    logic [ADC_W-1:0]      s_temp_sample = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ID_W-1:0]       m_frame_id;
    logic [LEN_W-1:0]      m_frame_length;
    logic [PAYLOAD_W-1:0]  m_payload;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // scheduler model state
    cfg_t cfg = '{evt_id: EVT_ID_RST, periodic_id: PERIODIC_ID_RST,
                  send_period: SEND_PERIOD_RST, temp_period: TEMP_PERIOD_RST};
    logic [STATUS_W-1:0] sw_status = '0;
    logic [STATUS_W-1:0] sent_status = '0;
    int                  speed_sum = 0;
    int                  avg_ticks = 0;
    logic [PERIOD_W-1:0] send_ticks = '0;
    logic [PERIOD_W-1:0] temp_ticks = '0;
    logic [SPEED_W-1:0]  speed_kmh = '0;
    logic [TEMP_W-1:0]   temp_deg = '0;

    request_t requests_todo[$];
    frame_t   frames_due[$];
    request_t in_flight;
    frame_t   want;

    int send_idle_pct = 19;
    int recv_idle_pct = 80;
    int stall_reqs = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int quiet = 0;
    int n_requests = 0;
    int n_events = 0;
    int n_periodic = 0;
    int n_bad = 0;
    int n_writes = 0;

    switch_sensor_frame_scheduler_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_speed_sample (s_speed_sample),
        .s_temp_sample  (s_temp_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_id     (m_frame_id),
        .m_frame_length (m_frame_length),
        .m_payload      (m_payload),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 aclk = ~aclk;

    task automatic advance_scheduler(input request_t rq);
        frame_t fr;
        int     avg;
        int     deg;
        if (rq.cmd != CMD_TICK) begin
            case (rq.cmd)
                CMD_HEADLIGHT: sw_status = sw_status ^ 3'b001;
                CMD_LEFT:      sw_status = (sw_status ^ 3'b010) & 3'b011;
                default:       sw_status = (sw_status ^ 3'b100) & 3'b101;
            endcase
            if (sw_status != sent_status) begin
                fr.frame_id     = cfg.evt_id;
                fr.frame_length = LEN_EVENT;
                fr.payload      = PAYLOAD_W'(sw_status);
                frames_due.push_back(fr);
                sent_status = sw_status;
            end
        end else begin
            speed_sum = speed_sum + int'(rq.speed);
            if (speed_sum > int'(SUM_MAX)) speed_sum = int'(SUM_MAX);
            if (avg_ticks < 255) avg_ticks++;
            send_ticks = send_ticks + 1'b1;
            temp_ticks = temp_ticks + 1'b1;
            if (avg_ticks >= AVG_WIN) begin
                avg = speed_sum / AVG_WIN;
                if (avg > int'(ADC_MAX)) avg = int'(ADC_MAX);
                speed_kmh = SPEED_W'((avg * int'(SPEED_SCALE)) / int'(ADC_MAX));
                speed_sum = 0;
                avg_ticks = 0;
            end
            if (send_ticks >= cfg.send_period) begin
                fr.frame_id     = cfg.periodic_id;
                fr.frame_length = LEN_PERIODIC;
                fr.payload      = {5'd0, sw_status, temp_deg, 1'b0, speed_kmh};
                frames_due.push_back(fr);
                send_ticks = '0;
            end
            if (temp_ticks >= cfg.temp_period) begin
                deg = (int'(rq.temp) * int'(TEMP_SCALE)) / int'(ADC_MAX);
                if (deg < int'(TEMP_OFFSET)) temp_deg = '0;
                else if (deg - int'(TEMP_OFFSET) > int'(TEMP_CLAMP)) temp_deg = '1;
                else temp_deg = TEMP_W'(deg - int'(TEMP_OFFSET));
                temp_ticks = '0;
            end
        end
    endtask

    function automatic request_t make_request(input cmd_t c, input logic [ADC_W-1:0] spd,
                                              input logic [ADC_W-1:0] tmp);
        request_t rq;
        rq.cmd   = c;
        rq.speed = spd;
        rq.temp  = tmp;
        return rq;
    endfunction

    function automatic request_t random_request();
        int               pick;
        cmd_t             c;
        logic [ADC_W-1:0] spd;
        logic [ADC_W-1:0] tmp;
        pick = $urandom_range(99);
        if (pick < 55) c = CMD_TICK;
        else if (pick < 70) c = CMD_HEADLIGHT;
        else if (pick < 85) c = CMD_LEFT;
        else c = CMD_RIGHT;
        spd = ADC_W'($urandom);
        tmp = ADC_W'($urandom);
        case ($urandom_range(7))
            0: spd = '1;
            1: spd = '0;
            2: tmp = '1;
            3: tmp = '0;
            4: tmp = ADC_W'($urandom_range(160, 150));
            default: ;
        endcase
        return make_request(c, spd, tmp);
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_scheduler(in_flight);
                n_requests++;
            end
            if (!s_valid || s_ready) begin
                if (requests_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_flight = requests_todo.pop_front();
                    s_valid        <= 1'b1;
                    s_cmd          <= in_flight.cmd;
                    s_speed_sample <= in_flight.speed;
                    s_temp_sample  <= in_flight.temp;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with an occasional long hold-off
    always @(posedge aclk) begin
        if (stall_seen != stall_reqs) begin
            stall_seen <= stall_reqs;
            stall_left <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (m_frame_length == LEN_EVENT) n_events++;
            else n_periodic++;
            if (frames_due.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected frame: id %h len %0d payload %h",
                             m_frame_id, m_frame_length, m_payload);
            end else begin
                want = frames_due.pop_front();
                if (m_frame_id !== want.frame_id || m_frame_length !== want.frame_length ||
                    m_payload !== want.payload) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display({"frame %0d: expected id %h len %0d payload %h, ",
                                  "got id %h len %0d payload %h"},
                                 n_events + n_periodic, want.frame_id, want.frame_length,
                                 want.payload, m_frame_id, m_frame_length, m_payload);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("no progress for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
        @(posedge aclk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EVT_ID:      cfg.evt_id      = val[ID_W-1:0];
            REG_PERIODIC_ID: cfg.periodic_id = val[ID_W-1:0];
            REG_SEND_PERIOD: cfg.send_period = val[PERIOD_W-1:0];
            default:         cfg.temp_period = val[PERIOD_W-1:0];
        endcase
        n_writes++;
    endtask

    task automatic apply_config(input logic [ID_W-1:0] ev_id, input logic [ID_W-1:0] pr_id,
                                input logic [PERIOD_W-1:0] snd, input logic [PERIOD_W-1:0] tmp);
        write_reg(REG_EVT_ID, APB_DATA_W'(ev_id));
        write_reg(REG_PERIODIC_ID, APB_DATA_W'(pr_id));
        write_reg(REG_SEND_PERIOD, APB_DATA_W'(snd));
        write_reg(REG_TEMP_PERIOD, APB_DATA_W'(tmp));
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (requests_todo.size() != 0 || s_valid || frames_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [ID_W-1:0] ev_id, input logic [ID_W-1:0] pr_id,
                             input logic [PERIOD_W-1:0] snd, input logic [PERIOD_W-1:0] tmp,
                             input int s_pct, input int r_pct, input int count, input bit hold);
        int               n;
        logic [ADC_W-1:0] lvl;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        apply_config(ev_id, pr_id, snd, tmp);
        @(negedge aclk);
        n = 0;
        while (n < count) begin
            if ($urandom_range(19) == 0) begin
                // a full averaging window at one speed level
                lvl = ADC_W'($urandom);
                repeat (AVG_WIN)
                    requests_todo.push_back(make_request(CMD_TICK, lvl, ADC_W'($urandom)));
                n += AVG_WIN;
            end else begin
                requests_todo.push_back(random_request());
                n++;
            end
        end
        if (hold) stall_reqs++;
        wait_idle();
    endtask

    initial begin
        cmd_t presses[10] = '{CMD_HEADLIGHT, CMD_HEADLIGHT, CMD_LEFT, CMD_LEFT, CMD_RIGHT,
                              CMD_RIGHT, CMD_LEFT, CMD_RIGHT, CMD_HEADLIGHT, CMD_LEFT};
        int   dir_temps[12] = '{1023, 0, 155, 156, 1023, 512, 0, 1023, 310, 311, 1023, 0};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // presses at reset ids, indicators cancelling each other
        foreach (presses[i])
            requests_todo.push_back(make_request(presses[i], ADC_W'($urandom), ADC_W'($urandom)));
        wait_idle();

        // extreme ids, every tick periodic, temperature clamp edges
        apply_config('0, '1, 8'd1, 8'd1);
        @(negedge aclk);
        foreach (dir_temps[i])
            requests_todo.push_back(make_request(CMD_TICK, (i < AVG_WIN) ? '1 : '0,
                                                 ADC_W'(dir_temps[i])));
        wait_idle();

        run_phase(11'h123, 11'h456, 8'd15, 8'd20, 19, 80, 300, 1'b0);
        run_phase('1, '0, 8'd255, 8'd255, 19, 80, 300, 1'b0);
        // periods dropped under the running counts
        run_phase(11'd5, 11'd7, 8'd3, 8'd2, 80, 19, 250, 1'b0);
        run_phase('0, '1, 8'd0, 8'd0, 80, 19, 200, 1'b0);
        run_phase(EVT_ID_RST, PERIODIC_ID_RST, 8'd1, 8'd255, 0, 0, 200, 1'b1);
        run_phase(ID_W'($urandom), ID_W'($urandom), PERIOD_W'($urandom_range(40, 1)),
                  PERIOD_W'($urandom_range(40, 1)), 0, 0, 170, 1'b0);

        repeat (10) @(negedge aclk);
        $display("ran %0d press and tick requests through %0d register writes, periods 0 to 255",
                 n_requests, n_writes);
        $display("checked %0d event and %0d periodic frames, %0d errors, %0d frames missing",
                 n_events, n_periodic, n_bad, frames_due.size());
        if (n_bad == 0 && frames_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### sim.f
sv/ssfs_pkg.sv
sv/ssfs_apb_regs.sv
sv/ssfs_engine.sv
sv/switch_sensor_frame_scheduler_core.sv
dv/tb.sv
